>>> design/pact_pkg.sv
// shared types, constants and helpers for the connection throttle
`default_nettype none
package pact_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 64;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETENTION_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_CAP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BAN_LIMIT     = 3'd6;

  localparam logic [47:0] RST_WINDOW_LEN    = 48'd60000000000;
  localparam logic [47:0] RST_RETENTION_LEN = 48'd600000000000;
  localparam logic [15:0] RST_ATTEMPT_LIMIT = 16'd10;
  localparam logic [47:0] RST_BLOCK_BASE    = 48'd30000000000;
  localparam logic [47:0] RST_BLOCK_STEP    = 48'd30000000000;
  localparam logic [47:0] RST_BLOCK_CAP     = 48'd600000000000;
  localparam logic [15:0] RST_BAN_LIMIT     = 16'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_UPDATE,
    ST_MULT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic sweep_step;
    logic update;
    logic mult;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic full;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [62:0] seen_ns;
    logic [62:0] win_start;
    logic [62:0] blk_until;
    logic [15:0] attempts;
    logic [15:0] blocks;
  } entry_t;

  // later - earlier is positive and above limit
  function automatic logic span_exceeds(input logic [62:0] later,
                                        input logic [62:0] earlier,
                                        input logic [47:0] limit);
    logic [62:0] diff;
    diff = later - earlier;
    return (later > earlier) && (diff > {15'b0, limit});
  endfunction

endpackage
`default_nettype wire

>>> design/pact_ctrl.sv
// controller state machine for the connection throttle
`default_nettype none
module pact_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire pact_pkg::status_t sts,
  output logic                   in_stall,
  output pact_pkg::cmd_t         cmd
);

  pact_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pact_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pact_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pact_pkg::ST_SWEEP;
      end
      pact_pkg::ST_SWEEP: begin
        if (sts.sweep_done) begin
          state_nxt = sts.full ? pact_pkg::ST_FINISH : pact_pkg::ST_READ;
        end
      end
      pact_pkg::ST_READ:   state_nxt = pact_pkg::ST_UPDATE;
      pact_pkg::ST_UPDATE: state_nxt = pact_pkg::ST_MULT;
      pact_pkg::ST_MULT:   state_nxt = pact_pkg::ST_FINISH;
      pact_pkg::ST_FINISH: begin
        if (sts.out_free) state_nxt = pact_pkg::ST_IDLE;
      end
      default: state_nxt = pact_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      pact_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      pact_pkg::ST_SWEEP:  cmd.sweep_step = 1'b1;
      pact_pkg::ST_READ:   cmd = '0;
      pact_pkg::ST_UPDATE: cmd.update = 1'b1;
      pact_pkg::ST_MULT:   cmd.mult = 1'b1;
      pact_pkg::ST_FINISH: cmd.finish = 1'b1;
      default:             cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> design/pact_dp.sv
// datapath: config registers, entry table, sweep and penalty arithmetic
`default_nettype none
module pact_dp #(
  parameter int unsigned TABLE_ENTRIES = pact_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire pact_pkg::cmd_t                  cmd,
  output pact_pkg::status_t                    sts,
  input  wire logic                            cfg_we,
  input  wire logic [pact_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [pact_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [63:0]                     in_addr_hi,
  input  wire logic [63:0]                     in_addr_lo,
  input  wire logic [62:0]                     in_now_ns,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic                                 out_blocked,
  output logic                                 out_escalate_ban,
  output logic [62:0]                          out_blocked_until_ns,
  output logic [15:0]                          out_attempt_count,
  output logic [15:0]                          out_block_count,
  output logic                                 out_table_full
);

  localparam int unsigned AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = AW + 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);

  logic [47:0] window_len_r, retention_len_r, block_base_r, block_step_r, block_cap_r;
  logic [15:0] attempt_limit_r, ban_limit_r;

  logic [63:0] hi_r, lo_r;
  logic [62:0] now_r;

  logic [CNT_W-1:0]         cnt_r;
  logic                     pend_r;
  logic [AW-1:0]            pend_idx_r;
  logic                     hit_r, free_r;
  logic [AW-1:0]            hit_idx_r, free_idx_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  pact_pkg::entry_t mem [TABLE_ENTRIES];
  pact_pkg::entry_t rdata_r;
  logic [AW-1:0]    rd_addr, sel_idx;

  pact_pkg::entry_t w_ent_r, upd_ent, wdata;
  logic             trig_r, pend_blk_r, upd_trig, upd_pend;
  logic [15:0]      prior_r, upd_prior;
  logic [63:0]      extra_r;

  logic        keep, full, out_free, wen;
  logic [47:0] headroom, penalty;
  logic [63:0] until_sum;
  logic [62:0] blk_end;

  logic        out_valid_r, out_blocked_r, out_escalate_ban_r, out_table_full_r;
  logic [62:0] out_blocked_until_r;
  logic [15:0] out_attempt_count_r, out_block_count_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r    <= pact_pkg::RST_WINDOW_LEN;
      retention_len_r <= pact_pkg::RST_RETENTION_LEN;
      attempt_limit_r <= pact_pkg::RST_ATTEMPT_LIMIT;
      block_base_r    <= pact_pkg::RST_BLOCK_BASE;
      block_step_r    <= pact_pkg::RST_BLOCK_STEP;
      block_cap_r     <= pact_pkg::RST_BLOCK_CAP;
      ban_limit_r     <= pact_pkg::RST_BAN_LIMIT;
    end else if (cfg_we) begin
      case (cfg_idx)
        pact_pkg::REG_WINDOW_LEN:    window_len_r    <= cfg_wdata;
        pact_pkg::REG_RETENTION_LEN: retention_len_r <= cfg_wdata;
        pact_pkg::REG_ATTEMPT_LIMIT: attempt_limit_r <= cfg_wdata[15:0];
        pact_pkg::REG_BLOCK_BASE:    block_base_r    <= cfg_wdata;
        pact_pkg::REG_BLOCK_STEP:    block_step_r    <= cfg_wdata;
        pact_pkg::REG_BLOCK_CAP:     block_cap_r     <= cfg_wdata;
        pact_pkg::REG_BAN_LIMIT:     ban_limit_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi_r  <= in_addr_hi;
      lo_r  <= in_addr_lo;
      now_r <= in_now_ns;
    end
  end

  // entry under check survives pruning
  assign keep = valid_r[pend_idx_r] &&
                !(rdata_r.seen_ns != '0 &&
                  pact_pkg::span_exceeds(now_r, rdata_r.seen_ns, retention_len_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.load) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.sweep_step) begin
      if (cnt_r != CNT_END) begin
        pend_r <= 1'b1;
        cnt_r  <= cnt_r + 1'b1;
      end else begin
        pend_r <= 1'b0;
      end
      if (pend_r) begin
        if (keep && !hit_r && rdata_r.addr_hi == hi_r && rdata_r.addr_lo == lo_r) begin
          hit_r <= 1'b1;
        end
        if (!keep && !free_r) free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      pend_idx_r <= cnt_r[AW-1:0];
      if (pend_r) begin
        if (keep && !hit_r && rdata_r.addr_hi == hi_r && rdata_r.addr_lo == lo_r) begin
          hit_idx_r <= pend_idx_r;
        end
        if (!keep && !free_r) free_idx_r <= pend_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.sweep_step && pend_r) begin
      valid_r[pend_idx_r] <= keep;
    end else if (wen) begin
      valid_r[sel_idx] <= 1'b1;
    end
  end

  assign sel_idx = hit_r ? hit_idx_r : free_idx_r;
  assign rd_addr = cmd.sweep_step ? cnt_r[AW-1:0] : sel_idx;
  assign full    = !hit_r && !free_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (wen) mem[sel_idx] <= wdata;
  end

  // per-address update of window, attempts and blocks
  always_comb begin
    if (hit_r) begin
      upd_ent = rdata_r;
    end else begin
      upd_ent         = '0;
      upd_ent.addr_hi = hi_r;
      upd_ent.addr_lo = lo_r;
    end
    upd_ent.seen_ns = now_r;
    upd_trig  = 1'b0;
    upd_prior = '0;
    upd_pend  = (upd_ent.blk_until != '0) && (upd_ent.blk_until > now_r);
    if (!upd_pend) begin
      upd_ent.blk_until = '0;
      if (upd_ent.win_start == '0) begin
        upd_ent.win_start = now_r;
        upd_ent.attempts  = '0;
      end else if (pact_pkg::span_exceeds(now_r, upd_ent.win_start, window_len_r)) begin
        if (pact_pkg::span_exceeds(now_r, upd_ent.win_start, retention_len_r)) begin
          upd_ent.blocks = '0;
        end
        upd_ent.win_start = now_r;
        upd_ent.attempts  = '0;
      end
      if (upd_ent.attempts != 16'hFFFF) upd_ent.attempts = upd_ent.attempts + 1'b1;
      upd_trig = upd_ent.attempts >= attempt_limit_r;
      if (upd_trig) begin
        if (upd_ent.blocks != 16'hFFFF) upd_ent.blocks = upd_ent.blocks + 1'b1;
        upd_prior = upd_ent.blocks - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      w_ent_r    <= upd_ent;
      trig_r     <= upd_trig;
      pend_blk_r <= upd_pend;
      prior_r    <= upd_prior;
    end
    if (cmd.mult) extra_r <= 64'(prior_r) * 64'(block_step_r);
  end

  // penalty capped, end time saturating at the 63-bit limit
  assign headroom = block_cap_r - block_base_r;
  assign penalty  = (block_base_r >= block_cap_r || extra_r >= {16'b0, headroom}) ?
                    block_cap_r : block_base_r + extra_r[47:0];
  assign until_sum = {1'b0, now_r} + {16'b0, penalty};
  assign blk_end   = until_sum[63] ? '1 : until_sum[62:0];

  always_comb begin
    wdata = w_ent_r;
    if (trig_r) begin
      wdata.blk_until = blk_end;
      wdata.win_start = now_r;
      wdata.attempts  = '0;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign wen      = cmd.finish && out_free && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && out_free) begin
      out_table_full_r    <= full;
      out_blocked_r       <= !full && (pend_blk_r || trig_r);
      out_escalate_ban_r  <= !full && !pend_blk_r && trig_r &&
                             (w_ent_r.blocks >= ban_limit_r);
      out_attempt_count_r <= full ? '0 : w_ent_r.attempts;
      out_block_count_r   <= full ? '0 : w_ent_r.blocks;
      if (full) begin
        out_blocked_until_r <= '0;
      end else if (pend_blk_r) begin
        out_blocked_until_r <= w_ent_r.blk_until;
      end else if (trig_r) begin
        out_blocked_until_r <= blk_end;
      end else begin
        out_blocked_until_r <= '0;
      end
    end
  end

  assign sts.sweep_done = cmd.sweep_step && (cnt_r == CNT_END) && !pend_r;
  assign sts.full       = full;
  assign sts.out_free   = out_free;

  assign out_valid            = out_valid_r;
  assign out_blocked          = out_blocked_r;
  assign out_escalate_ban     = out_escalate_ban_r;
  assign out_blocked_until_ns = out_blocked_until_r;
  assign out_attempt_count    = out_attempt_count_r;
  assign out_block_count      = out_block_count_r;
  assign out_table_full       = out_table_full_r;

endmodule
`default_nettype wire

>>> design/per_address_connection_throttle_unit.sv
// Per-address connection throttle: each item is one connection attempt (128-bit
// address and time). The block walks the whole table once per item, reading one
// entry per cycle from a single-port entry memory to prune idle entries and find
// or allocate the address, then reads the entry, updates it, does the penalty
// multiply and writes the entry back. The result is registered when the item
// finishes and the next item can be accepted after that; a full table skips the
// read, update and multiply. One item is worked at a time; a finished result sits
// in an output register while the next item is accepted, and while that result
// is stalled the next item waits before its write-back.
`default_nettype none
module per_address_connection_throttle_unit #(
  parameter int unsigned TABLE_ENTRIES = pact_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [pact_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [pact_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [63:0]                     in_addr_hi,
  input  wire logic [63:0]                     in_addr_lo,
  input  wire logic [62:0]                     in_now_ns,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_blocked,
  output logic                                 out_escalate_ban,
  output logic [62:0]                          out_blocked_until_ns,
  output logic [15:0]                          out_attempt_count,
  output logic [15:0]                          out_block_count,
  output logic                                 out_table_full
);

  pact_pkg::cmd_t    cmd;
  pact_pkg::status_t sts;

  pact_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  pact_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_wdata            (cfg_wdata),
    .in_addr_hi           (in_addr_hi),
    .in_addr_lo           (in_addr_lo),
    .in_now_ns            (in_now_ns),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_blocked          (out_blocked),
    .out_escalate_ban     (out_escalate_ban),
    .out_blocked_until_ns (out_blocked_until_ns),
    .out_attempt_count    (out_attempt_count),
    .out_block_count      (out_block_count),
    .out_table_full       (out_table_full)
  );

  // an accepted item keeps the input closed while it is worked
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |->
      !out_blocked && !out_escalate_ban && out_blocked_until_ns == '0 &&
      out_attempt_count == '0 && out_block_count == '0)
    else $error("table full item carries nonzero fields");

  a_unblocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_blocked |-> out_blocked_until_ns == '0 && !out_escalate_ban)
    else $error("unblocked item carries block end time or ban");

endmodule
`default_nettype wire

>>> tb/pact_checker.sv
// scoreboard for the connection throttle: predicts each result and compares it
`timescale 1ns / 1ps
module pact_checker #(
  parameter int unsigned TABLE_ENTRIES = pact_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [pact_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [pact_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire logic [63:0]                     in_addr_hi,
  input  wire logic [63:0]                     in_addr_lo,
  input  wire logic [62:0]                     in_now_ns,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic                            out_blocked,
  input  wire logic                            out_escalate_ban,
  input  wire logic [62:0]                     out_blocked_until_ns,
  input  wire logic [15:0]                     out_attempt_count,
  input  wire logic [15:0]                     out_block_count,
  input  wire logic                            out_table_full,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   verdicts_seen,
  output int                                   blocks_seen,
  output int                                   full_seen
);

  localparam logic [62:0] TIME_MAX = {63{1'b1}};

  typedef struct packed {
    logic        blocked;
    logic        ban;
    logic [62:0] end_ns;
    logic [15:0] attempts;
    logic [15:0] blocks;
    logic        full;
  } verdict_t;

  logic [47:0] win_len, keep_len, blk_base, blk_step, blk_cap;
  logic [15:0] try_limit, ban_lim;

  logic        tbl_valid  [TABLE_ENTRIES];
  logic [63:0] tbl_hi     [TABLE_ENTRIES];
  logic [63:0] tbl_lo     [TABLE_ENTRIES];
  logic [62:0] tbl_seen   [TABLE_ENTRIES];
  logic [62:0] tbl_wstart [TABLE_ENTRIES];
  logic [62:0] tbl_until  [TABLE_ENTRIES];
  logic [15:0] tbl_tries  [TABLE_ENTRIES];
  logic [15:0] tbl_blocks [TABLE_ENTRIES];

  verdict_t verdict_q[$];

  function automatic logic older_than(logic [62:0] later, logic [62:0] earlier,
                                      logic [47:0] lim);
    return (later > earlier) && ((later - earlier) > {15'b0, lim});
  endfunction

  function automatic verdict_t throttle_attempt(logic [63:0] hi, logic [63:0] lo,
                                                logic [62:0] now);
    verdict_t v;
    int hit, spare;
    logic [63:0] prior, extra, penalty, end_sum;
    v = '0;
    hit = -1;
    spare = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (tbl_valid[i] && tbl_seen[i] != 0 && older_than(now, tbl_seen[i], keep_len))
        tbl_valid[i] = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (hit < 0 && tbl_hi[i] == hi && tbl_lo[i] == lo) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (hit < 0) begin
      if (spare < 0) begin
        v.full = 1'b1;
        return v;
      end
      hit = spare;
      tbl_valid[hit] = 1'b1;
      tbl_hi[hit] = hi;
      tbl_lo[hit] = lo;
      tbl_wstart[hit] = '0;
      tbl_until[hit] = '0;
      tbl_tries[hit] = '0;
      tbl_blocks[hit] = '0;
    end
    tbl_seen[hit] = now;
    if (tbl_until[hit] != 0) begin
      if (tbl_until[hit] > now) begin
        v.blocked = 1'b1;
        v.end_ns = tbl_until[hit];
        v.attempts = tbl_tries[hit];
        v.blocks = tbl_blocks[hit];
        return v;
      end
      tbl_until[hit] = '0;
    end
    if (tbl_wstart[hit] == 0) begin
      tbl_wstart[hit] = now;
      tbl_tries[hit] = '0;
    end else if (older_than(now, tbl_wstart[hit], win_len)) begin
      if (older_than(now, tbl_wstart[hit], keep_len)) tbl_blocks[hit] = '0;
      tbl_wstart[hit] = now;
      tbl_tries[hit] = '0;
    end
    if (tbl_tries[hit] != 16'hffff) tbl_tries[hit]++;
    v.attempts = tbl_tries[hit];
    v.blocks = tbl_blocks[hit];
    if (tbl_tries[hit] >= try_limit) begin
      if (tbl_blocks[hit] != 16'hffff) tbl_blocks[hit]++;
      prior = (tbl_blocks[hit] > 0) ? 64'(tbl_blocks[hit] - 16'd1) : 64'd0;
      extra = prior * 64'(blk_step);
      if (blk_base >= blk_cap || extra >= 64'(blk_cap - blk_base)) penalty = 64'(blk_cap);
      else penalty = 64'(blk_base) + extra;
      end_sum = 64'(now) + penalty;
      if (end_sum > 64'(TIME_MAX)) end_sum = 64'(TIME_MAX);
      tbl_until[hit] = end_sum[62:0];
      tbl_wstart[hit] = now;
      tbl_tries[hit] = '0;
      v.blocked = 1'b1;
      v.ban = tbl_blocks[hit] >= ban_lim;
      v.end_ns = end_sum[62:0];
      v.blocks = tbl_blocks[hit];
    end
    return v;
  endfunction

  assign pending = verdict_q.size();

  always @(posedge clk) begin
    verdict_t want, got;
    if (!rst_n) begin
      win_len <= pact_pkg::RST_WINDOW_LEN;
      keep_len <= pact_pkg::RST_RETENTION_LEN;
      try_limit <= pact_pkg::RST_ATTEMPT_LIMIT;
      blk_base <= pact_pkg::RST_BLOCK_BASE;
      blk_step <= pact_pkg::RST_BLOCK_STEP;
      blk_cap <= pact_pkg::RST_BLOCK_CAP;
      ban_lim <= pact_pkg::RST_BAN_LIMIT;
      for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
      verdict_q.delete();
      fail_count <= 0;
      verdicts_seen <= 0;
      blocks_seen <= 0;
      full_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          pact_pkg::REG_WINDOW_LEN:    win_len <= cfg_wdata;
          pact_pkg::REG_RETENTION_LEN: keep_len <= cfg_wdata;
          pact_pkg::REG_ATTEMPT_LIMIT: try_limit <= cfg_wdata[15:0];
          pact_pkg::REG_BLOCK_BASE:    blk_base <= cfg_wdata;
          pact_pkg::REG_BLOCK_STEP:    blk_step <= cfg_wdata;
          pact_pkg::REG_BLOCK_CAP:     blk_cap <= cfg_wdata;
          pact_pkg::REG_BAN_LIMIT:     ban_lim <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        verdict_q.push_back(throttle_attempt(in_addr_hi, in_addr_lo, in_now_ns));
      if (out_valid && !out_stall) begin
        got = '{out_blocked, out_escalate_ban, out_blocked_until_ns, out_attempt_count,
                out_block_count, out_table_full};
        verdicts_seen <= verdicts_seen + 1;
        if (got.blocked) blocks_seen <= blocks_seen + 1;
        if (got.full) full_seen <= full_seen + 1;
        if (verdict_q.size() == 0) begin
          if (fail_count < 10) $display("%0t: result with nothing expected", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display({"%0t: exp blk=%0b ban=%0b until=%0d att=%0d cnt=%0d full=%0b",
                        " got blk=%0b ban=%0b until=%0d att=%0d cnt=%0d full=%0b"},
                       $realtime, want.blocked, want.ban, want.end_ns, want.attempts,
                       want.blocks, want.full, got.blocked, got.ban, got.end_ns,
                       got.attempts, got.blocks, got.full);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/tb_per_address_connection_throttle_unit.sv
// stimulus and verdict for the per-address connection throttle
`timescale 1ns / 1ps
module tb_per_address_connection_throttle_unit;

  localparam logic [pact_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic [62:0] TIME_MAX = {63{1'b1}};
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [pact_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [pact_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic [63:0] in_addr_hi = '0, in_addr_lo = '0;
  logic [62:0] in_now_ns = '0;
  logic out_stall = 1'b0;
  wire in_stall, out_valid, out_blocked, out_escalate_ban, out_table_full;
  wire [62:0] out_blocked_until_ns;
  wire [15:0] out_attempt_count, out_block_count;
  int fail_count, pending, verdicts_seen, blocks_seen, full_seen;

  logic quiet = 1'b0;
  logic hold_off = 1'b0;
  logic hold_req = 1'b0;
  int cycles = 0;
  int stall_left = 0;
  int items_sent = 0;
  logic [62:0] clock_ns;
  logic [63:0] pool_hi[8], pool_lo[8];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  per_address_connection_throttle_unit uut (.*);

  pact_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall bursts, overridden by the long hold-off
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (1500) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_attempt(logic [63:0] hi, logic [63:0] lo, logic [62:0] now);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_addr_hi <= hi;
    in_addr_lo <= lo;
    in_now_ns <= now;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_reg(logic [pact_pkg::CFG_IDX_W-1:0] idx,
                           logic [pact_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // wait for all results, then for the block to go idle before touching registers
  task automatic program_limits(logic [47:0] win, logic [47:0] keep, logic [15:0] lim,
                                logic [47:0] base, logic [47:0] stp, logic [47:0] cap,
                                logic [15:0] ban);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (80) @(posedge clk);
    write_reg(pact_pkg::REG_WINDOW_LEN, win);
    write_reg(pact_pkg::REG_RETENTION_LEN, keep);
    write_reg(pact_pkg::REG_ATTEMPT_LIMIT, {32'($urandom), lim});
    write_reg(pact_pkg::REG_BLOCK_BASE, base);
    write_reg(pact_pkg::REG_BLOCK_STEP, stp);
    write_reg(pact_pkg::REG_BLOCK_CAP, cap);
    write_reg(pact_pkg::REG_BAN_LIMIT, {32'($urandom), ban});
    write_reg(REG_NONE, {$urandom, 16'($urandom)});
    cfg_we <= 1'b0;
  endtask

  // mostly a small pool of repeat offenders, some strangers and odd timestamps
  task automatic random_attempts(int count, int tmax);
    int pick;
    for (int i = 0; i < 8; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end
    repeat (count) begin
      pick = $urandom_range(0, 11);
      if (pick < 10) begin
        clock_ns = clock_ns + 63'($urandom_range(0, tmax));
        send_attempt(pool_hi[pick % 8], pool_lo[pick % 8], clock_ns);
      end else if (pick == 10) begin
        send_attempt({$urandom, $urandom}, {$urandom, $urandom}, clock_ns);
      end else begin
        case ($urandom_range(0, 2))
          0: send_attempt(pool_hi[0], pool_lo[0], '0);
          1: send_attempt(pool_hi[1], pool_lo[1], clock_ns - 63'($urandom_range(1, tmax)));
          default: send_attempt(pool_hi[2], pool_lo[2], {$urandom, $urandom});
        endcase
      end
    end
  endtask

  initial begin
    logic [63:0] ones;
    ones = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero time, extreme addresses and times
    send_attempt('0, '0, '0);
    send_attempt(ones, ones, TIME_MAX);
    send_attempt('0, '0, '0);
    send_attempt(ones, ones, 63'd1);

    program_limits(48'd100, 48'd1000, 16'd2, 48'd50, 48'd30, 48'd100, 16'd2);
    send_attempt(64'h1, 64'h2, 63'd10);
    send_attempt(64'h1, 64'h2, 63'd11);   // first block
    send_attempt(64'h1, 64'h2, 63'd20);   // still pending
    send_attempt(64'h1, 64'h2, 63'd70);
    send_attempt(64'h1, 64'h2, 63'd71);   // second block, ban
    send_attempt(64'h1, 64'h2, 63'd5);    // time going backwards
    send_attempt(64'h3, 64'h4, TIME_MAX - 63'd10);
    send_attempt(64'h3, 64'h4, TIME_MAX - 63'd9);  // end time saturates
    send_attempt(64'h1, 64'h2, 63'd5000); // pruned and re-added

    // fill the table with strangers
    program_limits('1, '1, 16'd3, 48'd10, 48'd10, 48'd40, 16'd1);
    clock_ns = 63'd100;
    repeat (70) begin
      clock_ns = clock_ns + 63'd1;
      send_attempt({$urandom, $urandom}, {$urandom, $urandom}, clock_ns);
    end

    program_limits(48'd1000, 48'd8000, 16'd3, 48'd500, 48'd300, 48'd2000, 16'd2);
    clock_ns = 63'd1;
    hold_req = 1'b1;
    random_attempts(90, 200);

    program_limits('0, '0, '0, '0, '0, '0, '0);
    random_attempts(80, 5);

    program_limits('1, '1, 16'hffff, '1, '1, '1, 16'hffff);
    random_attempts(60, 1000);

    program_limits(48'd5000, 48'd40000, 16'd1, 48'd900, 48'd100, 48'd300, 16'd3);
    random_attempts(90, 3000);

    program_limits(48'd2000, 48'd20000, 16'd4, 48'd100, 48'hffffffffff, 48'd1000000,
                   16'd4);
    quiet = 1'b1;
    random_attempts(120, 800);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d attempts over eight register settings; %0d results checked",
             items_sent, verdicts_seen);
    $display("results refused: %0d, table full: %0d", blocks_seen, full_seen);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

>>> sim.f
design/pact_pkg.sv
design/pact_ctrl.sv
design/pact_dp.sv
design/per_address_connection_throttle_unit.sv
tb/pact_checker.sv
tb/tb_per_address_connection_throttle_unit.sv
